/* hdl/msfb_pkg.sv */
// Package for the Modbus stop frame builder: payload structs, frame constants
// and the CRC-16/Modbus byte update function.
// Depends on nothing; every other file of the block imports it.
package msfb_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_A_REG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_B_REG = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0]  NODE_ADDR_RST  = 8'd1;
  localparam logic [15:0] SIDE_A_REG_RST = 16'd14;
  localparam logic [15:0] SIDE_B_REG_RST = 16'd29;

  // Frame constants.
  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam int          QUEUE_DEPTH_DEF = 2;

  // Byte positions within the eight-byte frame.
  localparam logic [2:0] POS_ADDR    = 3'd0;
  localparam logic [2:0] POS_FUNC    = 3'd1;
  localparam logic [2:0] POS_REG_HI  = 3'd2;
  localparam logic [2:0] POS_REG_LO  = 3'd3;
  localparam logic [2:0] POS_VAL_HI  = 3'd4;
  localparam logic [2:0] POS_VAL_LO  = 3'd5;
  localparam logic [2:0] POS_CRC_LO  = 3'd6;
  localparam logic [2:0] POS_CRC_HI  = 3'd7;

  // Side letters.
  localparam logic [7:0] SIDE_A_UC = 8'h41;
  localparam logic [7:0] SIDE_A_LC = 8'h61;
  localparam logic [7:0] SIDE_B_UC = 8'h42;
  localparam logic [7:0] SIDE_B_LC = 8'h62;

  typedef struct packed {
    logic [7:0] side_code;
    logic       stop_request;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_t;

  // Everything the back end needs to produce one frame.
  typedef struct packed {
    logic [7:0]  node_addr;
    logic [15:0] stop_reg;
    logic        stop_on;
  } desc_t;

  // One byte of CRC-16/Modbus, reflected, bit by bit.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* hdl/modbus_stop_frame_builder.sv */
// Top level of the Modbus RTU stop frame builder: front end, descriptor
// queue and byte serializer. Depends on msfb_pkg and the msfb_* modules.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  side_code, stop_request
//   out_     output     out_valid/out_stall  frame_byte, last_byte
//   cfg_     input      cfg_we               cfg_idx, cfg_wdata
//
// A request with side A or B yields an eight-byte function 06 frame, one
// byte per cycle on the byte-wide result channel while out_stall is low;
// the next frame starts after its last byte. The first byte is registered
// in the queue and the output register; unknown sides are taken, yielding nothing.
// Synchronous reset (rst_n low) empties the queue and restores the register
// defaults. An output stall holds the current byte; requests queue until full.
module modbus_stop_frame_builder #(
  parameter int QUEUE_DEPTH = msfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [msfb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [msfb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  msfb_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output msfb_pkg::out_t                  out_data
);
  import msfb_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  desc_t q_wdata;
  desc_t q_rdata;

  // Front end decodes the side and snapshots the configuration, so a
  // queued frame carries everything it needs.
  msfb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  msfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // The back end keeps the head descriptor in the queue until the last
  // byte of its frame is loaded into the output register.
  msfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* hdl/msfb_front.sv */
// Front end of the Modbus stop frame builder: configuration registers, side
// decoding and capture of a frame descriptor. Depends on msfb_pkg.
module msfb_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [msfb_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [msfb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  msfb_pkg::in_t                  in_data,
  input  logic                           q_full,
  output logic                           q_push,
  output msfb_pkg::desc_t                q_wdata
);
  import msfb_pkg::*;

  logic [7:0]  node_addr_r;
  logic [15:0] side_a_reg_r;
  logic [15:0] side_b_reg_r;
  logic        is_a;
  logic        is_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r  <= NODE_ADDR_RST;
      side_a_reg_r <= SIDE_A_REG_RST;
      side_b_reg_r <= SIDE_B_REG_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_NODE_ADDR:  node_addr_r  <= cfg_wdata[7:0];
        CFG_SIDE_A_REG: side_a_reg_r <= cfg_wdata;
        CFG_SIDE_B_REG: side_b_reg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_a = (in_data.side_code inside {SIDE_A_UC, SIDE_A_LC});
    is_b = (in_data.side_code inside {SIDE_B_UC, SIDE_B_LC});
  end

  // Unknown sides are accepted and dropped here.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && (is_a || is_b);

  always_comb begin
    q_wdata.node_addr = node_addr_r;
    q_wdata.stop_reg  = is_a ? side_a_reg_r : side_b_reg_r;
    q_wdata.stop_on   = in_data.stop_request;
  end

endmodule

/* hdl/msfb_queue.sv */
// Small descriptor queue between front and back end of the Modbus stop
// frame builder. Depends on msfb_pkg.
module msfb_queue #(
  parameter int DEPTH = msfb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  msfb_pkg::desc_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output msfb_pkg::desc_t rdata
);
  import msfb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t           mem_r [DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

/* hdl/msfb_back.sv */
// Back end of the Modbus stop frame builder: serializes one descriptor into
// eight frame bytes and folds the CRC in as the bytes go out. Depends on msfb_pkg.
module msfb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  msfb_pkg::desc_t q_rdata,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output msfb_pkg::out_t  out_data
);
  import msfb_pkg::*;

  logic [2:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;
  logic        can_load;
  logic        load;
  logic [7:0]  cur_byte;
  logic [15:0] crc_base;

  assign can_load = !out_valid_r || !out_stall;
  assign load     = can_load && !q_empty;
  assign q_pop    = load && (pos_r == POS_CRC_HI);
  assign crc_base = (pos_r == POS_ADDR) ? CRC_INIT : crc_r;

  always_comb begin
    case (pos_r)
      POS_ADDR:   cur_byte = q_rdata.node_addr;
      POS_FUNC:   cur_byte = FUNC_WRITE_SINGLE;
      POS_REG_HI: cur_byte = q_rdata.stop_reg[15:8];
      POS_REG_LO: cur_byte = q_rdata.stop_reg[7:0];
      POS_VAL_HI: cur_byte = 8'h00;
      POS_VAL_LO: cur_byte = {7'd0, q_rdata.stop_on};
      POS_CRC_LO: cur_byte = crc_r[7:0];
      POS_CRC_HI: cur_byte = crc_r[15:8];
      default:    cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (can_load) begin
      out_valid_nxt = load;
    end
    if (load) begin
      pos_nxt                 = pos_r + 1'b1;
      out_data_nxt.frame_byte = cur_byte;
      out_data_nxt.last_byte  = (pos_r == POS_CRC_HI);
      if (pos_r <= POS_VAL_LO) begin
        crc_nxt = crc_byte(crc_base, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_ADDR;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r      <= crc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
